// ----- rtl/hdis_pkg.sv -----
`default_nettype none

package hdis_pkg;

  // Slot count of a boot-protocol keyboard report
  localparam int unsigned MAX_SLOTS = 6;

  // Fixed frame bytes and checksum seed
  localparam logic [7:0] FRAME_LEN_BYTE = 8'h84;
  localparam logic [7:0] VCP_SET_OP     = 8'h03;
  localparam logic [7:0] CHK_SEED       = 8'h6E;

  // Shortest report that is evaluated
  localparam logic [6:0] MIN_REPORT_LEN = 7'd8;

  // Register reset values
  localparam logic [7:0]  RST_HOTKEY_A  = 8'h04;
  localparam logic [7:0]  RST_HOTKEY_B  = 8'h05;
  localparam logic [7:0]  RST_SRC_ADDR  = 8'h50;
  localparam logic [7:0]  RST_FEATURE   = 8'hF4;
  localparam logic [15:0] RST_VALUE_A   = 16'h0090;
  localparam logic [15:0] RST_VALUE_B   = 16'h00D0;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_HOTKEY_A = 3'd0,
    CFG_HOTKEY_B = 3'd1,
    CFG_SRC_ADDR = 3'd2,
    CFG_FEATURE  = 3'd3,
    CFG_VALUE_A  = 3'd4,
    CFG_VALUE_B  = 3'd5
  } cfg_reg_e;

  // What one lane found in its slot
  typedef struct packed {
    logic hit_a;  // new press of the first hotkey
    logic hit_b;  // new press of the second hotkey
  } hdis_hit_t;

  // Merged decision for one report
  typedef struct packed {
    logic [1:0] count;      // number of switch frames, 0..2
    logic       first_tgt;  // target of the first frame
    logic       next_tgt;   // current target after the report
  } hdis_merge_t;

endpackage

`default_nettype wire

// ----- rtl/hdis_lane.sv -----
`default_nettype none

module hdis_lane
  import hdis_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 6,
  parameter int unsigned LANE_IDX  = 0
) (
  input  wire logic [NUM_SLOTS-1:0][7:0] keys_i,
  input  wire logic [NUM_SLOTS-1:0][7:0] prev_i,
  input  wire logic [7:0]                hotkey_a_i,
  input  wire logic [7:0]                hotkey_b_i,
  output hdis_hit_t                      hit_o
);

  logic [7:0] key;
  logic       fresh;

  // Check this slot against the stored keys and the earlier slots
  always_comb begin
    key   = keys_i[LANE_IDX];
    fresh = (key != 8'd0);
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if (prev_i[j] == key) begin
        fresh = 1'b0;
      end
      if ((j < LANE_IDX) && (keys_i[j] == key)) begin
        fresh = 1'b0;
      end
    end
    // First hotkey wins when both codes are equal
    hit_o.hit_a = fresh && (key == hotkey_a_i);
    hit_o.hit_b = fresh && (key != hotkey_a_i) && (key == hotkey_b_i);
  end

endmodule

`default_nettype wire

// ----- rtl/hdis_merge.sv -----
`default_nettype none

module hdis_merge
  import hdis_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 6
) (
  input  wire hdis_hit_t [NUM_SLOTS-1:0] hits_i,
  input  wire logic                      cur_i,
  output hdis_merge_t                    result_o
);

  logic any_a;
  logic any_b;
  logic found;
  logic first;

  // Find the earliest hotkey hit in slot order
  always_comb begin
    any_a = 1'b0;
    any_b = 1'b0;
    found = 1'b0;
    first = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      any_a = any_a | hits_i[i].hit_a;
      any_b = any_b | hits_i[i].hit_b;
      if (!found && (hits_i[i].hit_a || hits_i[i].hit_b)) begin
        found = 1'b1;
        first = hits_i[i].hit_b;
      end
    end
  end

  // Each hotkey acts once; with both, the second hit selects the other target
  always_comb begin
    result_o = '{count: 2'd0, first_tgt: first, next_tgt: cur_i};
    if (any_a && any_b) begin
      result_o.next_tgt = ~first;
      if (first != cur_i) begin
        result_o.count     = 2'd2;
        result_o.first_tgt = first;
      end else begin
        result_o.count     = 2'd1;
        result_o.first_tgt = ~first;
      end
    end else if (found) begin
      result_o.next_tgt = first;
      result_o.count    = (first != cur_i) ? 2'd1 : 2'd0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hotkey_ddc_input_switch.sv -----
// Hotkey monitor input switch.
// Input channel (in_valid_i/in_ready_o): one keyboard report per beat, six key
// slots plus the report length. Reports shorter than 8 bytes are dropped.
// Output channel (out_valid_o/out_ready_i): one beat per input switch, carrying
// the 7-byte VCP-set frame, the USB select level and last_of_run_o.
// Configuration channel (cfg_valid_i/cfg_ready_o): always ready; index 0..5
// selects hotkeys, source address, feature code and the two input values.
// One lane per key slot checks for a new hotkey press; a merge stage orders
// the hits and updates the current target and stored keys in the accept cycle.
// The first frame of a report appears in the cycle after acceptance.
// One report per cycle when it switches at most once and the receiver is
// ready; the pending-frame register limits it when a report switches twice.
// When the receiver stalls, the frame holds and a new report is taken only in
// the cycle its last frame leaves. Reset clears stored keys, sets target zero
// and loads the register defaults.
`default_nettype none

module hotkey_ddc_input_switch
  import hdis_pkg::*;
#(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  key_slot_0_i,
  input  wire logic [7:0]  key_slot_1_i,
  input  wire logic [7:0]  key_slot_2_i,
  input  wire logic [7:0]  key_slot_3_i,
  input  wire logic [7:0]  key_slot_4_i,
  input  wire logic [7:0]  key_slot_5_i,
  input  wire logic [6:0]  report_length_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       frame_byte_0_o,
  output logic [7:0]       frame_byte_1_o,
  output logic [7:0]       frame_byte_2_o,
  output logic [7:0]       frame_byte_3_o,
  output logic [7:0]       frame_byte_4_o,
  output logic [7:0]       frame_byte_5_o,
  output logic [7:0]       frame_checksum_o,
  output logic             usb_select_o,
  output logic             last_of_run_o
);

  // Configuration registers
  logic [7:0]  hotkey_a_q;
  logic [7:0]  hotkey_b_q;
  logic [7:0]  src_addr_q;
  logic [7:0]  feature_q;
  logic [15:0] value_a_q;
  logic [15:0] value_b_q;

  // Block state
  logic [KEY_SLOTS-1:0][7:0] prev_q, prev_d;
  logic                      cur_q, cur_d;
  logic [1:0]                rem_q, rem_d;
  logic                      tgt_q, tgt_d;

  logic [MAX_SLOTS-1:0][7:0] slot_all;
  logic [KEY_SLOTS-1:0][7:0] keys_w;
  hdis_hit_t [KEY_SLOTS-1:0] hits_w;
  hdis_merge_t               merge_w;
  logic                      in_fire;
  logic                      out_fire;
  logic                      report_ok;
  logic [15:0]               value_w;

  // Gather the slots that are scanned
  assign slot_all = {key_slot_5_i, key_slot_4_i, key_slot_3_i,
                     key_slot_2_i, key_slot_1_i, key_slot_0_i};
  assign keys_w   = slot_all[KEY_SLOTS-1:0];

  // One lane per slot
  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    hdis_lane #(
      .NUM_SLOTS (KEY_SLOTS),
      .LANE_IDX  (g)
    ) u_lane (
      .keys_i     (keys_w),
      .prev_i     (prev_q),
      .hotkey_a_i (hotkey_a_q),
      .hotkey_b_i (hotkey_b_q),
      .hit_o      (hits_w[g])
    );
  end

  hdis_merge #(
    .NUM_SLOTS (KEY_SLOTS)
  ) u_merge (
    .hits_i   (hits_w),
    .cur_i    (cur_q),
    .result_o (merge_w)
  );

  // Handshakes
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (rem_q != 2'd0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign in_ready_o  = (rem_q == 2'd0) || ((rem_q == 2'd1) && out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign report_ok   = (report_length_i >= MIN_REPORT_LEN);

  // Advance the pending frames, load a new run on accept
  always_comb begin
    rem_d  = rem_q;
    tgt_d  = tgt_q;
    cur_d  = cur_q;
    prev_d = prev_q;
    if (out_fire) begin
      rem_d = rem_q - 2'd1;
      tgt_d = ~tgt_q;
    end
    if (in_fire && report_ok) begin
      rem_d  = merge_w.count;
      tgt_d  = merge_w.first_tgt;
      cur_d  = merge_w.next_tgt;
      prev_d = keys_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= 2'd0;
      cur_q  <= 1'b0;
      prev_q <= '0;
    end else begin
      rem_q  <= rem_d;
      cur_q  <= cur_d;
      prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q <= tgt_d;
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hotkey_a_q <= RST_HOTKEY_A;
      hotkey_b_q <= RST_HOTKEY_B;
      src_addr_q <= RST_SRC_ADDR;
      feature_q  <= RST_FEATURE;
      value_a_q  <= RST_VALUE_A;
      value_b_q  <= RST_VALUE_B;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_HOTKEY_A: hotkey_a_q <= cfg_data_i[7:0];
        CFG_HOTKEY_B: hotkey_b_q <= cfg_data_i[7:0];
        CFG_SRC_ADDR: src_addr_q <= cfg_data_i[7:0];
        CFG_FEATURE:  feature_q  <= cfg_data_i[7:0];
        CFG_VALUE_A:  value_a_q  <= cfg_data_i;
        CFG_VALUE_B:  value_b_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Build the frame for the pending target
  assign value_w          = tgt_q ? value_b_q : value_a_q;
  assign frame_byte_0_o   = src_addr_q;
  assign frame_byte_1_o   = FRAME_LEN_BYTE;
  assign frame_byte_2_o   = VCP_SET_OP;
  assign frame_byte_3_o   = feature_q;
  assign frame_byte_4_o   = value_w[15:8];
  assign frame_byte_5_o   = value_w[7:0];
  assign frame_checksum_o = CHK_SEED ^ src_addr_q ^ FRAME_LEN_BYTE ^ VCP_SET_OP
                          ^ feature_q ^ value_w[15:8] ^ value_w[7:0];
  assign usb_select_o     = tgt_q;
  assign last_of_run_o    = (rem_q == 2'd1);

`ifndef SYNTHESIS
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q != 2'd3)
    else $error("pending frame count out of range");

  a_run_alternates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && (rem_q == 2'd2) |=>
      out_valid_o && (usb_select_o != $past(usb_select_o)))
    else $error("second frame of a run must select the other target");

  a_short_keeps_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !report_ok |=> $stable(prev_q) && $stable(cur_q))
    else $error("short report changed the stored state");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && last_of_run_o && !in_fire |=> !out_valid_o)
    else $error("frame shown after the last of its run");
`endif

endmodule

`default_nettype wire
